[rtl/ptn_pkg.sv]
// Shared widths, constants and result status codes for the port name parser.
package ptn_pkg;

    localparam int PORT_BITS  = 16;
    localparam int CH_W       = 8;
    localparam int SUB_W      = 8;
    localparam int PORT_W     = PORT_BITS + 1;
    localparam int BASE_W     = 4;
    localparam int DIG_W      = 7;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    localparam logic [CH_W-1:0]  CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0]  CH_PLUS  = 8'h2B;
    localparam logic [SUB_W-1:0] MAX_SUB  = 8'd15;

    typedef enum logic [1:0] {
        ST_SYMBOLIC = 2'd0,
        ST_NUMERIC  = 2'd1,
        ST_PASS     = 2'd2,
        ST_FAIL     = 2'd3
    } status_t;

endpackage

[rtl/port_name_to_number_parser.sv]
// Port name parser: one character per request in, one status/port result per name out.
// A name's last character passes through the input register and then the result register before its result is valid.
// Throughput: one character per cycle; a result can stall while one more character
// waits in the input register, and non-final characters keep flowing past a stalled result.
// The decode is a single registered pass: input register, character classify and
// multiply-by-ten update, result register.
// Reset (rst_n low, async): pipeline empty, parser state back to start of name.
module port_name_to_number_parser
(
    input  logic                            clk,
    input  logic                            rst_n,
    // s_axis_tdata: [7:0] ch, [15:8] subport
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ptn_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                            s_axis_tlast,   // is_last
    // m_axis_tdata: [16:0] port_number, [20:17] base_subport, [23:21] zero
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ptn_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic [1:0]                      m_axis_tuser    // status
);
    import ptn_pkg::*;

    // symbolic name tracker: X, Y, up to two base digits, optional '+'
    typedef enum logic [2:0] {
        SP_FIRST  = 3'd0,
        SP_SECOND = 3'd1,
        SP_XY     = 3'd2,
        SP_ONEDIG = 3'd3,
        SP_TWODIG = 3'd4,
        SP_PLUS   = 3'd5,
        SP_DEAD   = 3'd6
    } sym_phase_t;

    // numeric name tracker: digits then a single trailing '+'
    typedef enum logic [1:0] {
        NP_DIGITS = 2'd0,
        NP_PLUS   = 2'd1,
        NP_DEAD   = 2'd2
    } num_phase_t;

    function automatic logic is_alpha(input logic [CH_W-1:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [CH_W-1:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [CH_W-1:0] to_upper(input logic [CH_W-1:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

    // input register
    logic                   in_valid_reg, in_valid_next;
    logic [CH_W-1:0]        in_ch_reg, in_ch_next;
    logic [SUB_W-1:0]       in_sub_reg, in_sub_next;
    logic                   in_last_reg, in_last_next;

    // parser state
    sym_phase_t             sym_reg, sym_next;
    num_phase_t             num_reg, num_next;
    logic [CH_W-1:0]        first_reg, first_next;
    logic [CH_W-1:0]        second_reg, second_next;
    logic [DIG_W-1:0]       digit_reg, digit_next;
    logic                   rollup_reg, rollup_next;
    logic [PORT_BITS-1:0]   acc_reg, acc_next;
    logic                   ended_reg, ended_next;

    // result register
    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg, out_status_next;
    logic [PORT_W-1:0]      out_port_reg, out_port_next;
    logic [BASE_W-1:0]      out_base_reg, out_base_next;

    // state after absorbing the held character
    sym_phase_t             sym_abs;
    num_phase_t             num_abs;
    logic [CH_W-1:0]        first_abs, second_abs;
    logic [DIG_W-1:0]       digit_abs;
    logic                   rollup_abs;
    logic [PORT_BITS-1:0]   acc_abs;
    logic                   ended_abs;

    logic                   s_accept;
    logic                   advance;
    logic [3:0]             dval;
    logic [DIG_W-1:0]       digit_x10;
    logic [PORT_BITS-1:0]   acc_x10;
    logic                   sym_ok;
    logic                   rollup_ok;
    logic [8:0]             combined;
    logic [CH_W-1:0]        y_upper;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    // final characters need the result slot; others move on regardless
    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign dval      = in_ch_reg[3:0];
    assign digit_x10 = {digit_reg[DIG_W-4:0], 3'b000} + {digit_reg[DIG_W-2:0], 1'b0};
    assign acc_x10   = {acc_reg[PORT_BITS-4:0], 3'b000} + {acc_reg[PORT_BITS-2:0], 1'b0};

    // character absorb
    always_comb
    begin
        sym_abs    = sym_reg;
        num_abs    = num_reg;
        first_abs  = first_reg;
        second_abs = second_reg;
        digit_abs  = digit_reg;
        rollup_abs = rollup_reg;
        acc_abs    = acc_reg;
        ended_abs  = ended_reg;

        if (!ended_reg)
        begin
            if (in_ch_reg == CH_NUL)
            begin
                // NUL ends the name; later characters are ignored
                ended_abs = 1'b1;
            end
            else
            begin
                case (sym_reg)
                    SP_FIRST:
                    begin
                        if (is_alpha(in_ch_reg))
                        begin
                            first_abs = in_ch_reg;
                            sym_abs   = SP_SECOND;
                        end
                        else
                            sym_abs = SP_DEAD;
                    end
                    SP_SECOND:
                    begin
                        if (is_alpha(in_ch_reg) || is_digit(in_ch_reg))
                        begin
                            second_abs = in_ch_reg;
                            sym_abs    = SP_XY;
                        end
                        else
                            sym_abs = SP_DEAD;
                    end
                    SP_XY:
                    begin
                        if (is_digit(in_ch_reg))
                        begin
                            digit_abs = {3'b000, dval};
                            sym_abs   = SP_ONEDIG;
                        end
                        else if (in_ch_reg == CH_PLUS)
                        begin
                            rollup_abs = 1'b1;
                            sym_abs    = SP_PLUS;
                        end
                        else
                            sym_abs = SP_DEAD;
                    end
                    SP_ONEDIG:
                    begin
                        if (is_digit(in_ch_reg))
                        begin
                            digit_abs = digit_x10 + {3'b000, dval};
                            sym_abs   = (digit_abs > 7'd15) ? SP_DEAD : SP_TWODIG;
                        end
                        else if (in_ch_reg == CH_PLUS)
                        begin
                            rollup_abs = 1'b1;
                            sym_abs    = SP_PLUS;
                        end
                        else
                            sym_abs = SP_DEAD;
                    end
                    SP_TWODIG:
                    begin
                        if (in_ch_reg == CH_PLUS)
                        begin
                            rollup_abs = 1'b1;
                            sym_abs    = SP_PLUS;
                        end
                        else
                            sym_abs = SP_DEAD;
                    end
                    default:
                        sym_abs = SP_DEAD;
                endcase

                if (num_reg == NP_DIGITS)
                begin
                    if (is_digit(in_ch_reg))
                        acc_abs = acc_x10 + {{(PORT_BITS-4){1'b0}}, dval};
                    else if (in_ch_reg == CH_PLUS)
                        num_abs = NP_PLUS;
                    else
                        num_abs = NP_DEAD;
                end
                else
                    num_abs = NP_DEAD;
            end
        end
    end

    // end-of-name decode
    assign sym_ok    = sym_abs inside {SP_XY, SP_ONEDIG, SP_TWODIG, SP_PLUS};
    assign rollup_ok = (sym_abs == SP_XY) || rollup_abs;
    assign combined  = {2'b00, digit_abs} + {1'b0, in_sub_reg};
    assign y_upper   = to_upper(second_abs);

    always_comb
    begin
        out_status_next = out_status_reg;
        out_port_next   = out_port_reg;
        out_base_next   = out_base_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;

        in_valid_next = in_valid_reg;
        in_ch_next    = in_ch_reg;
        in_sub_next   = in_sub_reg;
        in_last_next  = in_last_reg;

        sym_next    = sym_reg;
        num_next    = num_reg;
        first_next  = first_reg;
        second_next = second_reg;
        digit_next  = digit_reg;
        rollup_next = rollup_reg;
        acc_next    = acc_reg;
        ended_next  = ended_reg;

        if (advance)
            in_valid_next = 1'b0;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
            in_ch_next    = s_axis_tdata[CH_W-1:0];
            in_sub_next   = s_axis_tdata[CH_W +: SUB_W];
            in_last_next  = s_axis_tlast;
        end

        if (advance)
        begin
            if (in_last_reg)
            begin
                out_valid_next = 1'b1;
                out_port_next  = '0;
                out_base_next  = '0;
                if (sym_ok)
                begin
                    if ((in_sub_reg != '0 && !rollup_ok) || combined > 9'd15)
                        out_status_next = ST_FAIL;
                    else
                    begin
                        out_status_next = ST_SYMBOLIC;
                        out_base_next   = combined[BASE_W-1:0];
                        // range pair, X[4:0], upper(Y)[5:0], subport[2:0]
                        out_port_next   = {1'b0, (combined[3] ? 2'b10 : 2'b01),
                                           first_abs[4:0], y_upper[5:0], combined[2:0]};
                    end
                end
                else if (num_abs == NP_PLUS)
                begin
                    if (in_sub_reg > MAX_SUB)
                        out_status_next = ST_FAIL;
                    else
                    begin
                        out_status_next = ST_NUMERIC;
                        out_port_next   = {1'b0, acc_abs}
                                        + {{(PORT_W-SUB_W){1'b0}}, in_sub_reg};
                    end
                end
                else
                    out_status_next = (in_sub_reg != '0) ? ST_FAIL : ST_PASS;

                // back to start of name
                sym_next    = SP_FIRST;
                num_next    = NP_DIGITS;
                first_next  = '0;
                second_next = '0;
                digit_next  = '0;
                rollup_next = 1'b0;
                acc_next    = '0;
                ended_next  = 1'b0;
            end
            else
            begin
                sym_next    = sym_abs;
                num_next    = num_abs;
                first_next  = first_abs;
                second_next = second_abs;
                digit_next  = digit_abs;
                rollup_next = rollup_abs;
                acc_next    = acc_abs;
                ended_next  = ended_abs;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            in_ch_reg      <= '0;
            in_sub_reg     <= '0;
            in_last_reg    <= 1'b0;
            sym_reg        <= SP_FIRST;
            num_reg        <= NP_DIGITS;
            first_reg      <= '0;
            second_reg     <= '0;
            digit_reg      <= '0;
            rollup_reg     <= 1'b0;
            acc_reg        <= '0;
            ended_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_PASS;
            out_port_reg   <= '0;
            out_base_reg   <= '0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            in_ch_reg      <= in_ch_next;
            in_sub_reg     <= in_sub_next;
            in_last_reg    <= in_last_next;
            sym_reg        <= sym_next;
            num_reg        <= num_next;
            first_reg      <= first_next;
            second_reg     <= second_next;
            digit_reg      <= digit_next;
            rollup_reg     <= rollup_next;
            acc_reg        <= acc_next;
            ended_reg      <= ended_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_port_reg   <= out_port_next;
            out_base_reg   <= out_base_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-PORT_W-BASE_W){1'b0}}, out_base_reg, out_port_reg};

endmodule

[rtl/ptn_checker.sv]
// Port-level checks for the port name parser, bound to the top level.
module ptn_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ptn_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic [1:0]                      m_axis_tuser
);
    import ptn_pkg::*;

    logic [PORT_W-1:0] port_f;
    logic [BASE_W-1:0] base_f;

    assign port_f = m_axis_tdata[PORT_W-1:0];
    assign base_f = m_axis_tdata[PORT_W +: BASE_W];

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // pass-through and fail carry no port
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_PASS || m_axis_tuser == ST_FAIL) |->
            port_f == '0 && base_f == '0)
        else $error("nonzero port on pass-through or fail");

    // symbolic packing agrees with the reported subport
    a_sym_pack: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ST_SYMBOLIC |->
            port_f[PORT_W-1] == 1'b0 && port_f[2:0] == base_f[2:0] &&
            port_f[15:14] == (base_f[3] ? 2'b10 : 2'b01))
        else $error("symbolic port packing mismatch");

    // numeric rollup has no base subport and stays in range
    a_num_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ST_NUMERIC |->
            base_f == '0 && port_f <= 17'd65550)
        else $error("numeric result out of range");

    // unused padding stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:PORT_W+BASE_W] == '0)
        else $error("padding bits set");

endmodule

bind port_name_to_number_parser ptn_checker u_ptn_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
